[sv/mtd_pkg.sv]
// Shared types and constants for the MIDI text dump note parser.
// No dependencies.
package mtd_pkg;

	// Quotient bits produced by the restoring divider (bit 16 down to bit 0).
	localparam int DIV_STEPS = 17;

	// Commands from the controller to the arithmetic datapath.
	typedef struct packed {
		logic load;
		logic mul_step;
		logic div_step;
		logic out_load;
	} mtd_cmd_t;

	// Status from the character scanner to the controller.
	typedef struct packed {
		logic emit;
		logic note;
	} mtd_scan_stat_t;

endpackage

[sv/mtd_scan.sv]
// Character scanner: keyword matchers, field mode and decimal accumulators.
// Depends on mtd_pkg.
module mtd_scan #(
	parameter int NUMBER_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [7:0]                   text_char,
	output mtd_pkg::mtd_scan_stat_t      stat,
	output logic [NUMBER_WIDTH-2:0]      ticks,
	output logic [NUMBER_WIDTH-2:0]      tempo,
	output logic [NUMBER_WIDTH-2:0]      delta,
	output logic [7:0]                   ch_sat,
	output logic [7:0]                   tone_sat,
	output logic [7:0]                   vel_sat
);
	import mtd_pkg::*;

	localparam int AW = NUMBER_WIDTH - 1;

	localparam logic [2:0] MODE_IDLE  = 3'd0;
	localparam logic [2:0] MODE_DIV   = 3'd1;
	localparam logic [2:0] MODE_TEMPO = 3'd2;
	localparam logic [2:0] MODE_DELTA = 3'd3;
	localparam logic [2:0] MODE_CH    = 3'd4;
	localparam logic [2:0] MODE_TONE  = 3'd5;
	localparam logic [2:0] MODE_VEL   = 3'd6;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	function automatic logic [1:0] div_match(logic [1:0] n, logic [7:0] c);
		logic [7:0] k;
		case (n)
			2'd0:    k = 8'h44; // D
			2'd1:    k = 8'h49; // I
			2'd2:    k = 8'h56; // V
			default: k = 8'h44;
		endcase
		return (c == k) ? ((n == 2'd3) ? 2'd1 : n + 2'd1) : 2'd0;
	endfunction

	function automatic logic [2:0] tempo_match(logic [2:0] n, logic [7:0] c);
		logic [7:0] k;
		logic [2:0] m;
		m = (n >= 3'd4) ? 3'd0 : n;
		case (m)
			3'd0:    k = 8'h54; // T
			3'd1:    k = 8'h65; // e
			3'd2:    k = 8'h6D; // m
			3'd3:    k = 8'h70; // p
			default: k = 8'h54;
		endcase
		return (c == k) ? m + 3'd1 : 3'd0;
	endfunction

	function automatic logic [2:0] delta_match(logic [2:0] n, logic [7:0] c);
		logic [7:0] k;
		logic [2:0] m;
		m = (n >= 3'd5) ? 3'd0 : n;
		case (m)
			3'd0:    k = 8'h44; // D
			3'd1:    k = 8'h45; // E
			3'd2:    k = 8'h4C; // L
			3'd3:    k = 8'h54; // T
			3'd4:    k = 8'h41; // A
			default: k = 8'h44;
		endcase
		return (c == k) ? m + 3'd1 : 3'd0;
	endfunction

	logic [1:0]    div_cnt_q, div_cnt_d, div_n;
	logic [2:0]    tempo_cnt_q, tempo_cnt_d, tempo_n;
	logic [2:0]    delta_cnt_q, delta_cnt_d, delta_n;
	logic [2:0]    mode_q, mode_d;
	logic [AW-1:0] ticks_q, tempo_q, delta_q, ch_q, tone_q, vel_q;
	logic [AW-1:0] ticks_d, tempo_d, delta_d, ch_d, tone_d, vel_d;
	logic [AW-1:0] acc_sel, acc_next;
	logic [AW+3:0] acc_x10;
	logic          is_digit;
	logic [3:0]    digit;
	logic [7:0]    char_off;

	assign is_digit = (text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE);
	assign char_off = text_char - CHAR_ZERO;
	assign digit    = char_off[3:0];

	always_comb begin
		case (mode_q)
			MODE_DIV:   acc_sel = ticks_q;
			MODE_TEMPO: acc_sel = tempo_q;
			MODE_DELTA: acc_sel = delta_q;
			MODE_CH:    acc_sel = ch_q;
			MODE_TONE:  acc_sel = tone_q;
			default:    acc_sel = vel_q;
		endcase
	end

	// v*10 + d, saturating at the largest positive value
	assign acc_x10  = ({4'd0, acc_sel} << 3) + ({4'd0, acc_sel} << 1) + {{AW{1'b0}}, digit};
	assign acc_next = (|acc_x10[AW+3:AW]) ? {AW{1'b1}} : acc_x10[AW-1:0];

	assign div_n   = div_match(div_cnt_q, text_char);
	assign tempo_n = tempo_match(tempo_cnt_q, text_char);
	assign delta_n = delta_match(delta_cnt_q, text_char);

	always_comb begin
		div_cnt_d   = div_cnt_q;
		tempo_cnt_d = tempo_cnt_q;
		delta_cnt_d = delta_cnt_q;
		mode_d      = mode_q;
		ticks_d     = ticks_q;
		tempo_d     = tempo_q;
		delta_d     = delta_q;
		ch_d        = ch_q;
		tone_d      = tone_q;
		vel_d       = vel_q;
		stat.emit   = 1'b0;
		stat.note   = (mode_q == MODE_VEL);
		case (mode_q)
			MODE_DIV, MODE_TEMPO, MODE_DELTA, MODE_CH, MODE_TONE, MODE_VEL: begin
				if (is_digit) begin
					case (mode_q)
						MODE_DIV:   ticks_d = acc_next;
						MODE_TEMPO: tempo_d = acc_next;
						MODE_DELTA: delta_d = acc_next;
						MODE_CH:    ch_d    = acc_next;
						MODE_TONE:  tone_d  = acc_next;
						default:    vel_d   = acc_next;
					endcase
				end else begin
					case (mode_q)
						MODE_DELTA: begin
							ch_d   = '0;
							mode_d = MODE_CH;
						end
						MODE_CH: begin
							if (ch_q != '0) begin
								tone_d = '0;
								mode_d = MODE_TONE;
							end else begin
								mode_d = MODE_IDLE;
								if (delta_q != '0) begin
									tone_d    = '0;
									vel_d     = '0;
									stat.emit = 1'b1;
								end
							end
						end
						MODE_TONE: begin
							vel_d  = '0;
							mode_d = MODE_VEL;
						end
						MODE_VEL: begin
							mode_d    = MODE_IDLE;
							stat.emit = 1'b1;
						end
						default: mode_d = MODE_IDLE;
					endcase
				end
			end
			default: begin
				mode_d      = MODE_IDLE;
				div_cnt_d   = div_n;
				tempo_cnt_d = tempo_n;
				delta_cnt_d = delta_n;
				if (div_n == 2'd3) begin
					div_cnt_d = 2'd0;
					ticks_d   = '0;
					mode_d    = MODE_DIV;
				end else if (tempo_n == 3'd4) begin
					tempo_cnt_d = 3'd0;
					tempo_d     = '0;
					mode_d      = MODE_TEMPO;
				end else if (delta_n == 3'd5) begin
					delta_cnt_d = 3'd0;
					delta_d     = '0;
					mode_d      = MODE_DELTA;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q   <= '0;
			tempo_cnt_q <= '0;
			delta_cnt_q <= '0;
			mode_q      <= MODE_IDLE;
			ticks_q     <= '0;
			tempo_q     <= '0;
			delta_q     <= '0;
			ch_q        <= '0;
			tone_q      <= '0;
			vel_q       <= '0;
		end else if (accept) begin
			div_cnt_q   <= div_cnt_d;
			tempo_cnt_q <= tempo_cnt_d;
			delta_cnt_q <= delta_cnt_d;
			mode_q      <= mode_d;
			ticks_q     <= ticks_d;
			tempo_q     <= tempo_d;
			delta_q     <= delta_d;
			ch_q        <= ch_d;
			tone_q      <= tone_d;
			vel_q       <= vel_d;
		end
	end

	assign ticks    = ticks_q;
	assign tempo    = tempo_q;
	assign delta    = delta_q;
	assign ch_sat   = (|ch_q[AW-1:8])   ? 8'hFF : ch_q[7:0];
	assign tone_sat = (|tone_q[AW-1:8]) ? 8'hFF : tone_q[7:0];
	assign vel_sat  = (|vel_q[AW-1:8])  ? 8'hFF : vel_q[7:0];

endmodule

[sv/mtd_arith.sv]
// Arithmetic datapath: shift-add multiplier, restoring divider, result register.
// Depends on mtd_pkg; sequenced by mtd_ctrl.
module mtd_arith #(
	parameter int NUMBER_WIDTH = 32
) (
	input  logic                    clk,
	input  mtd_pkg::mtd_cmd_t       cmd,
	input  logic                    note,
	input  logic [NUMBER_WIDTH-2:0] ticks,
	input  logic [NUMBER_WIDTH-2:0] tempo,
	input  logic [NUMBER_WIDTH-2:0] delta,
	input  logic [7:0]              ch_sat,
	input  logic [7:0]              tone_sat,
	input  logic [7:0]              vel_sat,
	output logic [15:0]             delta_ms,
	output logic [7:0]              channel,
	output logic [7:0]              tone,
	output logic [7:0]              velocity
);
	import mtd_pkg::*;

	localparam int AW = NUMBER_WIDTH - 1;
	localparam int PW = 2 * AW;
	localparam int NW = AW + 10;
	localparam int DW = NW + DIV_STEPS - 1;
	localparam int XW = (PW > DW) ? PW : DW;

	logic [PW-1:0]        prod_q;
	logic [AW-1:0]        mcand_q;
	logic [DW-1:0]        dsh_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [7:0]           ch_q, tone_q, vel_q;
	logic [15:0]          dms_q;
	logic [7:0]           ch_out_q, tone_out_q, vel_out_q;

	logic [NW-1:0]        den;
	logic [AW:0]          mul_sum;
	logic [XW-1:0]        rem_x, dsh_x, diff_x;
	logic                 ge;

	// ticks * 1000 = ticks*1024 - ticks*32 + ticks*8
	assign den = ({10'd0, ticks} << 10) - ({10'd0, ticks} << 5) + ({10'd0, ticks} << 3);

	assign mul_sum = {1'b0, prod_q[PW-1:AW]} + (prod_q[0] ? {1'b0, mcand_q} : {(AW+1){1'b0}});

	assign rem_x  = XW'(prod_q);
	assign dsh_x  = XW'(dsh_q);
	assign ge     = (rem_x >= dsh_x);
	assign diff_x = rem_x - dsh_x;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prod_q  <= {{AW{1'b0}}, tempo};
			mcand_q <= delta;
			dsh_q   <= {den, {(DIV_STEPS-1){1'b0}}};
			quo_q   <= '0;
			ch_q    <= note ? ch_sat : 8'd0;
			tone_q  <= note ? tone_sat : 8'd0;
			vel_q   <= note ? vel_sat : 8'd0;
		end else if (cmd.mul_step) begin
			prod_q <= {mul_sum, prod_q[AW-1:1]};
		end else if (cmd.div_step) begin
			if (ge)
				prod_q <= diff_x[PW-1:0];
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[DIV_STEPS-2:0], ge};
		end
		if (cmd.out_load) begin
			dms_q      <= (|quo_q[DIV_STEPS-1:16]) ? 16'hFFFF : quo_q[15:0];
			ch_out_q   <= ch_q;
			tone_out_q <= tone_q;
			vel_out_q  <= vel_q;
		end
	end

	assign delta_ms = dms_q;
	assign channel  = ch_out_q;
	assign tone     = tone_out_q;
	assign velocity = vel_out_q;

endmodule

[sv/mtd_ctrl.sv]
// Controller: input/output handshakes and multiply/divide sequencing.
// Depends on mtd_pkg; drives mtd_arith.
module mtd_ctrl #(
	parameter int NUMBER_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  logic                    out_stall,
	input  mtd_pkg::mtd_scan_stat_t stat,
	output logic                    accept,
	output mtd_pkg::mtd_cmd_t       cmd
);
	import mtd_pkg::*;

	localparam int CW = $clog2(NUMBER_WIDTH + DIV_STEPS);

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	localparam logic [CW-1:0] MUL_LAST = CW'(NUMBER_WIDTH - 2);
	localparam logic [CW-1:0] DIV_LAST = CW'(DIV_STEPS - 1);

	logic [1:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic          out_valid_q, out_valid_d;
	logic          out_free;

	assign in_stall = (state_q != ST_RUN);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		cmd          = '0;
		out_valid_d  = out_valid_q && out_stall;
		case (state_q)
			ST_RUN: begin
				if (accept && stat.emit) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == MUL_LAST) begin
					cnt_d   = '0;
					state_d = ST_DIV;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST)
					state_d = ST_HOLD;
				else
					cnt_d = cnt_q + 1'b1;
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot0(cmd))
		else $error("more than one datapath command");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("pending item overwritten");

	a_load_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_MUL) && (cnt_q == '0))
		else $error("multiply did not start after load");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (cnt_q == DIV_LAST) |=> (state_q == ST_HOLD))
		else $error("divider did not finish");

endmodule

[sv/midi_text_dump_note_parser.sv]
// Top level of the MIDI text dump note parser.
// Depends on mtd_pkg, mtd_scan, mtd_arith and mtd_ctrl.
//
// Takes one character per cycle while in_stall is low. A character that
// completes a note or delta entry holds in_stall high while the item runs
// through the one-bit-per-cycle shift-add multiplier for delta*tempo, the
// restoring divider by division*1000 and the output register load, where it
// waits while out_stall holds a previous item. Other characters are taken
// one per cycle, also while an item waits at the output.
module midi_text_dump_note_parser #(
	parameter int NUMBER_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] delta_ms,
	output logic [7:0]  channel,
	output logic [7:0]  tone,
	output logic [7:0]  velocity
);
	import mtd_pkg::*;

	mtd_scan_stat_t          stat;
	mtd_cmd_t                cmd;
	logic                    accept;
	logic [NUMBER_WIDTH-2:0] ticks, tempo, delta;
	logic [7:0]              ch_sat, tone_sat, vel_sat;

	mtd_scan #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.text_char (text_char),
		.stat      (stat),
		.ticks     (ticks),
		.tempo     (tempo),
		.delta     (delta),
		.ch_sat    (ch_sat),
		.tone_sat  (tone_sat),
		.vel_sat   (vel_sat)
	);

	mtd_arith #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_arith (
		.clk      (clk),
		.cmd      (cmd),
		.note     (stat.note),
		.ticks    (ticks),
		.tempo    (tempo),
		.delta    (delta),
		.ch_sat   (ch_sat),
		.tone_sat (tone_sat),
		.vel_sat  (vel_sat),
		.delta_ms (delta_ms),
		.channel  (channel),
		.tone     (tone),
		.velocity (velocity)
	);

	mtd_ctrl #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.accept    (accept),
		.cmd       (cmd)
	);

endmodule

[test/mtd_note_checker.sv]
`timescale 1ns / 100ps
// Checker for the MIDI text dump note parser: watches both channels, predicts each
// result from the accepted characters and compares it with what the block emits.
// Standalone, no package dependencies.
module mtd_note_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  text_char,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] delta_ms,
	input  logic [7:0]  channel,
	input  logic [7:0]  tone,
	input  logic [7:0]  velocity,
	output int          errors,
	output int          pending,
	output int          results_total,
	output int          notes_total
);

	localparam logic [31:0] ACC_MAX = 32'h7FFF_FFFF;
	localparam logic [39:0] KW_DIV = "DIV";
	localparam logic [39:0] KW_TEMPO = "Temp";
	localparam logic [39:0] KW_DELTA = "DELTA";
	localparam int MAX_REPORTS = 10;

	typedef enum logic [2:0] {
		FM_IDLE, FM_DIV, FM_TEMPO, FM_DELTA, FM_CHAN, FM_TONE, FM_VEL
	} field_mode_t;

	typedef struct packed {
		logic [15:0] ms;
		logic [7:0]  ch;
		logic [7:0]  tn;
		logic [7:0]  vel;
	} note_t;

	note_t       expected_notes[$];
	field_mode_t mode;
	int          div_hits, tempo_hits, delta_hits;
	logic [31:0] fval [0:7];

	function automatic int kw_step(input int n, input logic [39:0] kw, input int len,
			input logic [7:0] c);
		if (n >= len)
			n = 0;
		return (c == kw[8*(len-1-n) +: 8]) ? n + 1 : 0;
	endfunction

	function automatic logic [15:0] scaled_ms();
		logic [63:0] num, den, q;
		if (fval[FM_DIV] == 32'd0)
			return 16'hFFFF;
		num = {32'd0, fval[FM_DELTA]} * {32'd0, fval[FM_TEMPO]};
		den = {32'd0, fval[FM_DIV]} * 64'd1000;
		q = num / den;
		return (q > 64'd65535) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic logic [7:0] sat8(input logic [31:0] v);
		return (v > 32'd255) ? 8'hFF : v[7:0];
	endfunction

	task automatic clear_parser();
		mode = FM_IDLE;
		div_hits = 0;
		tempo_hits = 0;
		delta_hits = 0;
		for (int i = 0; i < 8; i++)
			fval[i] = 32'd0;
		expected_notes.delete();
	endtask

	task automatic push_note(input logic with_note);
		note_t r;
		r.ms = scaled_ms();
		r.ch = with_note ? sat8(fval[FM_CHAN]) : 8'd0;
		r.tn = with_note ? sat8(fval[FM_TONE]) : 8'd0;
		r.vel = with_note ? sat8(fval[FM_VEL]) : 8'd0;
		expected_notes.push_back(r);
		results_total++;
		if (with_note)
			notes_total++;
	endtask

	task automatic parse_char(input logic [7:0] c);
		logic [31:0] acc, d;
		if (mode == FM_IDLE) begin
			div_hits = kw_step(div_hits, KW_DIV, 3, c);
			tempo_hits = kw_step(tempo_hits, KW_TEMPO, 4, c);
			delta_hits = kw_step(delta_hits, KW_DELTA, 5, c);
			if (div_hits == 3) begin
				div_hits = 0;
				fval[FM_DIV] = 32'd0;
				mode = FM_DIV;
			end else if (tempo_hits == 4) begin
				tempo_hits = 0;
				fval[FM_TEMPO] = 32'd0;
				mode = FM_TEMPO;
			end else if (delta_hits == 5) begin
				delta_hits = 0;
				fval[FM_DELTA] = 32'd0;
				mode = FM_DELTA;
			end
			return;
		end
		if (c >= "0" && c <= "9") begin
			acc = fval[mode];
			d = {24'd0, c - "0"};
			if (acc > (ACC_MAX - d) / 32'd10)
				acc = ACC_MAX;
			else
				acc = acc * 32'd10 + d;
			fval[mode] = acc;
			return;
		end
		case (mode)
			FM_DELTA: begin
				fval[FM_CHAN] = 32'd0;
				mode = FM_CHAN;
			end
			FM_CHAN: begin
				if (fval[FM_CHAN] != 32'd0) begin
					fval[FM_TONE] = 32'd0;
					mode = FM_TONE;
				end else begin
					mode = FM_IDLE;
					if (fval[FM_DELTA] != 32'd0) begin
						fval[FM_TONE] = 32'd0;
						fval[FM_VEL] = 32'd0;
						push_note(1'b0);
					end
				end
			end
			FM_TONE: begin
				fval[FM_VEL] = 32'd0;
				mode = FM_VEL;
			end
			FM_VEL: begin
				mode = FM_IDLE;
				push_note(1'b1);
			end
			default: mode = FM_IDLE;
		endcase
	endtask

	// Sampled mid-cycle: values here are the ones seen at the next rising edge.
	always @(negedge clk) begin : watch
		note_t e;
		if (!arst_n) begin
			clear_parser();
			errors = 0;
			results_total = 0;
			notes_total = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_notes.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected result ms=%0d ch=%0d tone=%0d vel=%0d",
							$realtime, delta_ms, channel, tone, velocity);
				end else begin
					e = expected_notes.pop_front();
					if (e.ms !== delta_ms || e.ch !== channel || e.tn !== tone ||
							e.vel !== velocity) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: mismatch exp ms=%0d ch=%0d tone=%0d vel=%0d, got ms=%0d ch=%0d tone=%0d vel=%0d",
								$realtime, e.ms, e.ch, e.tn, e.vel,
								delta_ms, channel, tone, velocity);
					end
				end
			end
			if (in_valid && !in_stall)
				parse_char(text_char);
		end
		pending = expected_notes.size();
	end

endmodule

[test/tb_midi_text_dump_note_parser.sv]
`timescale 1ns / 100ps
// Testbench top for the MIDI text dump note parser: drives the character stream
// and output stall, and gives the verdict. Depends on midi_text_dump_note_parser
// and mtd_note_checker.
module tb_midi_text_dump_note_parser;

	localparam int LONG_HOLD = 400;
	localparam int SETTLE_CYCLES = 60;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_CHARS = 290;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  text_char;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] delta_ms;
	logic [7:0]  channel;
	logic [7:0]  tone;
	logic [7:0]  velocity;

	int errors, pending, results_total, notes_total;
	int send_idle, recv_stall, hold_token;
	int chars_sent, noise_sent;

	midi_text_dump_note_parser DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .text_char(text_char),
		.out_valid(out_valid), .out_stall(out_stall),
		.delta_ms(delta_ms), .channel(channel), .tone(tone), .velocity(velocity)
	);

	mtd_note_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .text_char(text_char),
		.out_valid(out_valid), .out_stall(out_stall),
		.delta_ms(delta_ms), .channel(channel), .tone(tone), .velocity(velocity),
		.errors(errors), .pending(pending),
		.results_total(results_total), .notes_total(notes_total)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout with %0d results outstanding", pending);
		$display("TEST FAILED");
		$finish;
	end

	// Output side: random stall, plus a long hold whenever hold_token moves.
	initial begin : receiver
		int hold_left, hold_seen;
		hold_left = 0;
		hold_seen = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall);
			end
		end
	end

	function automatic logic [7:0] non_digit();
		logic [7:0] c;
		c = 8'($urandom);
		if (c >= "0" && c <= "9")
			c = c ^ 8'h40;
		return c;
	endfunction

	task automatic put_char(input logic [7:0] c);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			text_char <= 8'($urandom);
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		text_char <= c;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		chars_sent++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i]);
	endtask

	task automatic put_number(input int min_len, input int max_len);
		repeat ($urandom_range(max_len, min_len))
			put_char(8'("0" + $urandom_range(9)));
	endtask

	task automatic put_sep();
		if ($urandom_range(9) != 0)
			put_char(" ");
		else
			put_char(non_digit());
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic put_record();
		int k, n, start;
		string kw;
		k = $urandom_range(99);
		if (k < 8) begin
			put_text("DIV");
			if ($urandom_range(9) == 0) put_number(0, 11);
			else put_number(2, 3);
			put_sep();
		end else if (k < 16) begin
			put_text("Temp");
			if ($urandom_range(9) == 0) put_number(0, 11);
			else put_number(5, 6);
			put_sep();
		end else if (k < 72) begin
			put_text("DELTA");
			if ($urandom_range(9) == 0) put_number(0, 11);
			else put_number(1, 3);
			put_sep();
			if ($urandom_range(5) == 0) put_char("0");
			else put_number(1, ($urandom_range(7) == 0) ? 4 : 2);
			put_sep();
			put_number(1, ($urandom_range(7) == 0) ? 5 : 3);
			put_sep();
			put_number(1, ($urandom_range(7) == 0) ? 5 : 3);
			put_sep();
		end else if (k < 86) begin
			case ($urandom_range(2))
				0: kw = "DIV";
				1: kw = "Temp";
				default: kw = "DELTA";
			endcase
			n = $urandom_range(kw.len() - 1, 1);
			if ($urandom_range(3) == 0)
				put_char(kw[0]);
			for (int i = 0; i < n; i++)
				put_char(kw[i]);
			put_char(non_digit());
		end else begin
			start = chars_sent;
			repeat ($urandom_range(6, 1))
				put_char(8'($urandom));
			noise_sent += chars_sent - start;
		end
	endtask

	initial begin : stimulus
		int target;
		arst_n = 1'b0;
		in_valid = 1'b0;
		text_char = 8'd0;
		send_idle = 0;
		recv_stall = 0;
		hold_token = 0;
		chars_sent = 0;
		noise_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero division, then a regular note entry
		put_text("DIV0 DELTA5 1 60 100 ");
		put_text("DIV480 Temp500000 DELTA480 1 60 100 ");
		put_text("DELTA0 2 0 0 ");
		// zero channel with and without a delta
		put_text("DELTA250 0 DELTA0 0 ");
		// accumulator and output saturation, large quotient
		put_text("DELTA99999999999 300 256 999 ");
		put_text("DIV1 Temp9 DELTA9 9 9 9 ");
		// matcher drops on a miss without rechecking the char
		put_text("DDIV7 DELDIV960 TTemp Temp500000 ");
		// field terminator is consumed, not matched
		put_text("DIV480DELTA5 1 1 1 DIV480 ");
		put_text("DELTA12E34 5x6y7z");
		// bytes above 127 and the byte extremes act as separators
		put_text("DELTA");
		put_char(8'hC4);
		put_char("7");
		put_char(8'h00);
		put_char("9");
		put_char(8'hFF);
		put_text("127");
		put_char(8'hB0);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall <= 0;  end
				1: begin send_idle = 80; recv_stall <= 0;  end
				2: begin send_idle = 0;  recv_stall <= 80; end
				default: begin send_idle = 11; recv_stall <= 11; end
			endcase
			if (ph == 0) begin
				put_text("DIV96 Temp600000 ");
				hold_token <= hold_token + 1;
				repeat (6)
					put_text("DELTA120 3 64 90 ");
			end
			target = chars_sent - noise_sent + PHASE_CHARS;
			while (chars_sent - noise_sent < target)
				put_record();
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d characters (%0d noise) over four pacing modes and a long output hold;",
			chars_sent, noise_sent);
		$display("checked %0d results, %0d note entries and %0d delta-only, %0d errors.",
			results_total, notes_total, results_total - notes_total, errors);
		if (errors == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
